// ----- hdl/rcim_pkg.sv -----
package rcim_pkg;

  localparam int STICK_BITS_DEF = 12;
  localparam int RANGE_BITS     = 12;
  localparam int DEADBAND_BITS  = 15;
  localparam int GAIN_BITS      = 24;
  localparam int GAIN_FRAC      = 8;
  localparam int MOUSE_BITS     = 16;
  localparam int Q_BITS         = 15;
  localparam int AXIS_BITS      = Q_BITS + 1;
  localparam int NUM_LANES      = 5;
  localparam int QUEUE_DEPTH    = 2;
  localparam int APB_ADDR_BITS  = 4;
  localparam int APB_DATA_BITS  = 32;

  localparam int LANE_LEFT_X  = 0;
  localparam int LANE_LEFT_Y  = 1;
  localparam int LANE_RIGHT_X = 2;
  localparam int LANE_RIGHT_Y = 3;
  localparam int LANE_WHEEL   = 4;

  localparam logic [RANGE_BITS-1:0]    RANGE_RST    = RANGE_BITS'(660);
  localparam logic [DEADBAND_BITS-1:0] DEADBAND_RST = DEADBAND_BITS'(1638);
  localparam logic [AXIS_BITS-1:0]     FULL_Q15     = AXIS_BITS'(32767);

  typedef enum logic [1:0] {
    REG_STICK_RANGE      = 2'd0,
    REG_DEADBAND         = 2'd1,
    REG_MOUSE_YAW_GAIN   = 2'd2,
    REG_MOUSE_PITCH_GAIN = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    SW_UNKNOWN = 2'd0,
    SW_UP      = 2'd1,
    SW_MIDDLE  = 2'd2,
    SW_DOWN    = 2'd3
  } switch_e;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_MANUAL = 2'd1,
    MODE_AUTO   = 2'd2,
    MODE_SAFE   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_OFFLINE  = 2'd0,
    KIND_INVALID  = 2'd1,
    KIND_REMOTE   = 2'd2,
    KIND_KEYBOARD = 2'd3
  } kind_e;

  typedef enum logic {
    SRC_REMOTE   = 1'b0,
    SRC_KEYBOARD = 1'b1
  } source_e;

  typedef enum logic [2:0] {
    BK_IDLE = 3'd0,
    BK_DIV1 = 3'd1,
    BK_MID  = 3'd2,
    BK_DIV2 = 3'd3,
    BK_FIN  = 3'd4
  } back_state_e;

  typedef struct packed {
    kind_e                         kind;
    mode_e                         mode;
    logic [3:0]                    keys;
    logic signed [MOUSE_BITS-1:0]  mouse_dx;
    logic signed [MOUSE_BITS-1:0]  mouse_dy;
    logic [1:0]                    buttons;
  } cmd_t;

  typedef struct packed {
    logic load;
    logic step;
    logic phase2;
    logic mid;
  } lane_ctl_t;

endpackage

// ----- hdl/rcim_front.sv -----
module rcim_front #(
  parameter int STICK_BITS = rcim_pkg::STICK_BITS_DEF
) (
  input  logic                                       start_i,
  input  logic                                       full_i,
  input  logic                                       link_live_i,
  input  logic [1:0]                                 left_switch_i,
  input  logic [1:0]                                 right_switch_i,
  input  logic signed [STICK_BITS-1:0]               left_stick_x_i,
  input  logic signed [STICK_BITS-1:0]               left_stick_y_i,
  input  logic signed [STICK_BITS-1:0]               right_stick_x_i,
  input  logic signed [STICK_BITS-1:0]               right_stick_y_i,
  input  logic signed [STICK_BITS-1:0]               wheel_value_i,
  input  logic [15:0]                                key_bits_i,
  input  logic signed [rcim_pkg::MOUSE_BITS-1:0]     mouse_dx_i,
  input  logic signed [rcim_pkg::MOUSE_BITS-1:0]     mouse_dy_i,
  input  logic [1:0]                                 mouse_buttons_i,
  output logic                                       busy_o,
  output logic                                       push_o,
  output rcim_pkg::cmd_t                             cmd_o,
  output logic [rcim_pkg::NUM_LANES*STICK_BITS-1:0]  sticks_o
);

  rcim_pkg::switch_e ls;
  rcim_pkg::switch_e rs;

  assign ls     = rcim_pkg::switch_e'(left_switch_i);
  assign rs     = rcim_pkg::switch_e'(right_switch_i);
  assign busy_o = full_i;
  assign push_o = start_i && !full_i;

  always_comb begin
    cmd_o.keys     = key_bits_i[3:0];
    cmd_o.mouse_dx = mouse_dx_i;
    cmd_o.mouse_dy = mouse_dy_i;
    cmd_o.buttons  = mouse_buttons_i;
    cmd_o.mode     = rcim_pkg::MODE_NONE;
    if (!link_live_i) begin
      cmd_o.kind = rcim_pkg::KIND_OFFLINE;
    end else if (ls == rcim_pkg::SW_UNKNOWN || rs == rcim_pkg::SW_UNKNOWN) begin
      cmd_o.kind = rcim_pkg::KIND_INVALID;
    end else begin
      cmd_o.kind = (rs == rcim_pkg::SW_UP) ? rcim_pkg::KIND_KEYBOARD
                                           : rcim_pkg::KIND_REMOTE;
      case (ls)
        rcim_pkg::SW_MIDDLE: cmd_o.mode = rcim_pkg::MODE_MANUAL;
        rcim_pkg::SW_UP:     cmd_o.mode = rcim_pkg::MODE_AUTO;
        default:             cmd_o.mode = rcim_pkg::MODE_SAFE;
      endcase
    end
  end

  always_comb begin
    sticks_o = '0;
    sticks_o[rcim_pkg::LANE_LEFT_X*STICK_BITS +: STICK_BITS]  = left_stick_x_i;
    sticks_o[rcim_pkg::LANE_LEFT_Y*STICK_BITS +: STICK_BITS]  = left_stick_y_i;
    sticks_o[rcim_pkg::LANE_RIGHT_X*STICK_BITS +: STICK_BITS] = right_stick_x_i;
    sticks_o[rcim_pkg::LANE_RIGHT_Y*STICK_BITS +: STICK_BITS] = right_stick_y_i;
    sticks_o[rcim_pkg::LANE_WHEEL*STICK_BITS +: STICK_BITS]   = wheel_value_i;
  end

endmodule

// ----- hdl/rcim_queue.sv -----
module rcim_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int DEPTH = rcim_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- hdl/rcim_lane.sv -----
module rcim_lane #(
  parameter int STICK_BITS = rcim_pkg::STICK_BITS_DEF
) (
  input  logic                                     clk_i,
  input  rcim_pkg::lane_ctl_t                      ctl_i,
  input  logic signed [STICK_BITS-1:0]             raw_i,
  input  logic [rcim_pkg::RANGE_BITS-1:0]          range_i,
  input  logic [rcim_pkg::DEADBAND_BITS-1:0]       deadband_i,
  output logic [rcim_pkg::AXIS_BITS-1:0]           value_o
);

  localparam int QB   = rcim_pkg::Q_BITS;
  localparam int AW   = rcim_pkg::AXIS_BITS;
  localparam int NW   = 2 * QB + 1;
  localparam int CMPW = ((STICK_BITS > rcim_pkg::RANGE_BITS) ? STICK_BITS
                                                              : rcim_pkg::RANGE_BITS) + 1;
  localparam logic [AW-1:0] ONE_Q15 = AW'(1) << QB;

  logic [STICK_BITS-1:0] raw_u;
  logic [STICK_BITS-1:0] mag;
  logic                  neg;
  logic                  sat;
  logic [AW-1:0]         span;
  logic [AW-1:0]         divisor;
  logic [AW-1:0]         trial;
  logic                  ge;
  logic [AW-1:0]         f_val;
  logic [AW-1:0]         diff;
  logic [NW-1:0]         numer;

  logic                  neg_q;
  logic                  sat_q;
  logic                  zero_q;
  logic [AW-1:0]         rem_q;
  logic [QB-1:0]         low_q;
  logic [QB-1:0]         quo_q;

  assign raw_u   = raw_i;
  assign neg     = raw_i[STICK_BITS-1];
  assign mag     = neg ? STICK_BITS'(~raw_u + 1'b1) : raw_u;
  assign sat     = CMPW'(mag) >= CMPW'(range_i);
  assign span    = ONE_Q15 - AW'(deadband_i);
  assign divisor = ctl_i.phase2 ? span : AW'(range_i);
  assign trial   = {rem_q[AW-2:0], ctl_i.phase2 ? low_q[QB-1] : 1'b0};
  assign ge      = trial >= divisor;
  assign f_val   = sat_q ? ONE_Q15 : {1'b0, quo_q};
  assign diff    = f_val - AW'(deadband_i);
  assign numer   = (NW'({diff, {QB{1'b0}}}) - NW'(diff)) + NW'(span >> 1);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      neg_q <= neg;
      sat_q <= sat;
      rem_q <= AW'(mag);
      quo_q <= '0;
      low_q <= '0;
    end else if (ctl_i.step) begin
      rem_q <= ge ? trial - divisor : trial;
      quo_q <= {quo_q[QB-2:0], ge};
      low_q <= {low_q[QB-2:0], 1'b0};
    end else if (ctl_i.mid) begin
      zero_q <= f_val <= AW'(deadband_i);
      rem_q  <= AW'(numer[NW-2:QB]);
      low_q  <= numer[QB-1:0];
      quo_q  <= '0;
    end
  end

  assign value_o = zero_q ? '0 : (neg_q ? AW'(-{1'b0, quo_q}) : {1'b0, quo_q});

endmodule

// ----- hdl/rcim_back.sv -----
module rcim_back #(
  parameter int STICK_BITS = rcim_pkg::STICK_BITS_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       empty_i,
  input  rcim_pkg::cmd_t                             cmd_i,
  input  logic [rcim_pkg::NUM_LANES*STICK_BITS-1:0]  sticks_i,
  output logic                                       pop_o,
  input  logic [rcim_pkg::RANGE_BITS-1:0]            range_i,
  input  logic [rcim_pkg::DEADBAND_BITS-1:0]         deadband_i,
  input  logic signed [rcim_pkg::GAIN_BITS-1:0]      yaw_gain_i,
  input  logic signed [rcim_pkg::GAIN_BITS-1:0]      pitch_gain_i,
  output logic                                       result_valid_o,
  output logic                                       status_o,
  output logic [1:0]                                 mode_o,
  output logic                                       source_o,
  output logic signed [rcim_pkg::AXIS_BITS-1:0]      chassis_forward_o,
  output logic signed [rcim_pkg::AXIS_BITS-1:0]      chassis_lateral_o,
  output logic signed [rcim_pkg::AXIS_BITS-1:0]      chassis_turn_o,
  output logic signed [rcim_pkg::AXIS_BITS-1:0]      gimbal_yaw_o,
  output logic signed [rcim_pkg::AXIS_BITS-1:0]      gimbal_pitch_o,
  output logic                                       friction_request_o,
  output logic                                       fire_request_o
);

  localparam int AW    = rcim_pkg::AXIS_BITS;
  localparam int QB    = rcim_pkg::Q_BITS;
  localparam int PRODW = rcim_pkg::MOUSE_BITS + rcim_pkg::GAIN_BITS;
  localparam int SHW   = PRODW - rcim_pkg::GAIN_FRAC;
  localparam int CNT_W = $clog2(QB);

  function automatic logic [AW-1:0] mouse_q15(input logic signed [PRODW-1:0] prod);
    logic [PRODW-1:0] mag;
    logic [PRODW-1:0] rnd;
    logic [SHW-1:0]   sh;
    logic [QB-1:0]    q;
    mag = prod[PRODW-1] ? PRODW'(-prod) : prod;
    rnd = mag + (PRODW'(1) << (rcim_pkg::GAIN_FRAC - 1));
    sh  = rnd[PRODW-1:rcim_pkg::GAIN_FRAC];
    q   = (sh > SHW'(rcim_pkg::FULL_Q15)) ? rcim_pkg::FULL_Q15[QB-1:0] : sh[QB-1:0];
    return prod[PRODW-1] ? {1'b0, q} : AW'(-{1'b0, q});
  endfunction

  function automatic logic [AW-1:0] key_axis(input logic plus, input logic minus);
    logic [AW-1:0] r;
    r = '0;
    if (plus && !minus) begin
      r = rcim_pkg::FULL_Q15;
    end else if (minus && !plus) begin
      r = AW'(-rcim_pkg::FULL_Q15);
    end
    return r;
  endfunction

  rcim_pkg::back_state_e state_q, state_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  rcim_pkg::cmd_t        cmd_q;
  logic signed [PRODW-1:0] prod_yaw_q;
  logic signed [PRODW-1:0] prod_pitch_q;
  rcim_pkg::lane_ctl_t   lane_ctl;
  logic [AW-1:0]         lane_val [rcim_pkg::NUM_LANES];
  logic                  cnt_last;
  logic                  valid_q;

  assign cnt_last = (cnt_q == CNT_W'(QB - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      rcim_pkg::BK_IDLE, rcim_pkg::BK_FIN: begin
        if (!empty_i) begin
          state_d = (cmd_i.kind == rcim_pkg::KIND_REMOTE) ? rcim_pkg::BK_DIV1
                                                          : rcim_pkg::BK_FIN;
        end else begin
          state_d = rcim_pkg::BK_IDLE;
        end
      end
      rcim_pkg::BK_DIV1: if (cnt_last) state_d = rcim_pkg::BK_MID;
      rcim_pkg::BK_MID:  state_d = rcim_pkg::BK_DIV2;
      rcim_pkg::BK_DIV2: if (cnt_last) state_d = rcim_pkg::BK_FIN;
      default:           state_d = rcim_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o           = 1'b0;
    lane_ctl        = '0;
    cnt_d           = '0;
    case (state_q)
      rcim_pkg::BK_IDLE, rcim_pkg::BK_FIN: begin
        pop_o         = !empty_i;
        lane_ctl.load = !empty_i;
      end
      rcim_pkg::BK_DIV1: begin
        lane_ctl.step = 1'b1;
        cnt_d         = cnt_last ? '0 : cnt_q + 1'b1;
      end
      rcim_pkg::BK_MID: begin
        lane_ctl.mid = 1'b1;
      end
      rcim_pkg::BK_DIV2: begin
        lane_ctl.step   = 1'b1;
        lane_ctl.phase2 = 1'b1;
        cnt_d           = cnt_last ? '0 : cnt_q + 1'b1;
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rcim_pkg::BK_IDLE;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      valid_q <= (state_q == rcim_pkg::BK_FIN);
    end
  end

  for (genvar g = 0; g < rcim_pkg::NUM_LANES; g++) begin : g_lane
    rcim_lane #(
      .STICK_BITS(STICK_BITS)
    ) u_lane (
      .clk_i      (clk_i),
      .ctl_i      (lane_ctl),
      .raw_i      (sticks_i[g*STICK_BITS +: STICK_BITS]),
      .range_i    (range_i),
      .deadband_i (deadband_i),
      .value_o    (lane_val[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q        <= cmd_i;
      prod_yaw_q   <= cmd_i.mouse_dx * yaw_gain_i;
      prod_pitch_q <= cmd_i.mouse_dy * pitch_gain_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == rcim_pkg::BK_FIN) begin
      status_o           <= 1'b0;
      mode_o             <= cmd_q.mode;
      source_o           <= rcim_pkg::SRC_REMOTE;
      chassis_forward_o  <= '0;
      chassis_lateral_o  <= '0;
      chassis_turn_o     <= '0;
      gimbal_yaw_o       <= '0;
      gimbal_pitch_o     <= '0;
      friction_request_o <= 1'b0;
      fire_request_o     <= 1'b0;
      case (cmd_q.kind)
        rcim_pkg::KIND_INVALID: begin
          status_o <= 1'b1;
          mode_o   <= rcim_pkg::MODE_NONE;
        end
        rcim_pkg::KIND_REMOTE: begin
          chassis_forward_o <= lane_val[rcim_pkg::LANE_LEFT_Y];
          chassis_lateral_o <= AW'(-lane_val[rcim_pkg::LANE_LEFT_X]);
          chassis_turn_o    <= lane_val[rcim_pkg::LANE_WHEEL];
          gimbal_yaw_o      <= AW'(-lane_val[rcim_pkg::LANE_RIGHT_X]);
          gimbal_pitch_o    <= lane_val[rcim_pkg::LANE_RIGHT_Y];
        end
        rcim_pkg::KIND_KEYBOARD: begin
          source_o           <= rcim_pkg::SRC_KEYBOARD;
          chassis_forward_o  <= key_axis(cmd_q.keys[0], cmd_q.keys[1]);
          chassis_lateral_o  <= key_axis(cmd_q.keys[2], cmd_q.keys[3]);
          gimbal_yaw_o       <= mouse_q15(prod_yaw_q);
          gimbal_pitch_o     <= mouse_q15(prod_pitch_q);
          friction_request_o <= cmd_q.buttons[1];
          fire_request_o     <= cmd_q.buttons[0];
        end
        default: begin
          mode_o <= rcim_pkg::MODE_NONE;
        end
      endcase
    end
  end

  assign result_valid_o = valid_q;

endmodule

// ----- hdl/remote_control_intent_mapper.sv -----
// Maps one remote-control frame to one operator intent (mode, source, five
// Q1.15 axis requests, shooter requests). A frame is taken when start is high
// and busy is low; it lands in a two-entry queue, so busy rises only when both
// entries are waiting. Offline, invalid and keyboard frames leave the queue as
// soon as the back end is idle or in its output state, go straight to that
// output state and raise result_valid_o from a register. The back end takes a
// new frame in its output state, so these frames sustain one frame per cycle
// while no stick frame holds the back end. For a stick frame, every stick lane
// runs a 15-step restoring division by the stick range register, a setup
// state, then a 15-step division by the deadband span, then the output state.
// Each result is flagged by result_valid_o for one cycle only and cannot be
// held off. Write the registers over APB only while no frame is in flight.
module remote_control_intent_mapper #(
  parameter int STICK_BITS = rcim_pkg::STICK_BITS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [rcim_pkg::APB_ADDR_BITS-1:0]      paddr,
  input  logic [rcim_pkg::APB_DATA_BITS-1:0]      pwdata,
  output logic [rcim_pkg::APB_DATA_BITS-1:0]      prdata,
  output logic                                    pready,
  input  logic                                    start,
  output logic                                    busy,
  input  logic                                    link_live_i,
  input  logic [1:0]                              left_switch_i,
  input  logic [1:0]                              right_switch_i,
  input  logic signed [STICK_BITS-1:0]            left_stick_x_i,
  input  logic signed [STICK_BITS-1:0]            left_stick_y_i,
  input  logic signed [STICK_BITS-1:0]            right_stick_x_i,
  input  logic signed [STICK_BITS-1:0]            right_stick_y_i,
  input  logic signed [STICK_BITS-1:0]            wheel_value_i,
  input  logic [15:0]                             key_bits_i,
  input  logic signed [rcim_pkg::MOUSE_BITS-1:0]  mouse_dx_i,
  input  logic signed [rcim_pkg::MOUSE_BITS-1:0]  mouse_dy_i,
  input  logic [1:0]                              mouse_buttons_i,
  output logic                                    result_valid_o,
  output logic                                    status_o,
  output logic [1:0]                              mode_o,
  output logic                                    source_o,
  output logic signed [rcim_pkg::AXIS_BITS-1:0]   chassis_forward_o,
  output logic signed [rcim_pkg::AXIS_BITS-1:0]   chassis_lateral_o,
  output logic signed [rcim_pkg::AXIS_BITS-1:0]   chassis_turn_o,
  output logic signed [rcim_pkg::AXIS_BITS-1:0]   gimbal_yaw_o,
  output logic signed [rcim_pkg::AXIS_BITS-1:0]   gimbal_pitch_o,
  output logic                                    friction_request_o,
  output logic                                    fire_request_o
);

  localparam int DW     = rcim_pkg::APB_DATA_BITS;
  localparam int STK_W  = rcim_pkg::NUM_LANES * STICK_BITS;
  localparam int CMD_W  = $bits(rcim_pkg::cmd_t);
  localparam int ENTRY_W = CMD_W + STK_W;

  logic [rcim_pkg::RANGE_BITS-1:0]        range_q;
  logic [rcim_pkg::DEADBAND_BITS-1:0]     deadband_q;
  logic signed [rcim_pkg::GAIN_BITS-1:0]  yaw_gain_q;
  logic signed [rcim_pkg::GAIN_BITS-1:0]  pitch_gain_q;
  logic [rcim_pkg::RANGE_BITS-1:0]        range_eff;
  rcim_pkg::reg_idx_e                     reg_idx;
  logic                                   wr_en;

  rcim_pkg::cmd_t    front_cmd;
  rcim_pkg::cmd_t    head_cmd;
  logic [STK_W-1:0]  front_sticks;
  logic [STK_W-1:0]  head_sticks;
  logic [ENTRY_W-1:0] head_entry;
  logic              push;
  logic              pop;
  logic              q_empty;
  logic              q_full;

  assign pready    = 1'b1;
  assign reg_idx   = rcim_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en     = psel && penable && pwrite && pready;
  assign range_eff = (range_q == '0) ? rcim_pkg::RANGE_BITS'(1) : range_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q      <= rcim_pkg::RANGE_RST;
      deadband_q   <= rcim_pkg::DEADBAND_RST;
      yaw_gain_q   <= '0;
      pitch_gain_q <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        rcim_pkg::REG_STICK_RANGE:      range_q      <= pwdata[rcim_pkg::RANGE_BITS-1:0];
        rcim_pkg::REG_DEADBAND:         deadband_q   <= pwdata[rcim_pkg::DEADBAND_BITS-1:0];
        rcim_pkg::REG_MOUSE_YAW_GAIN:   yaw_gain_q   <= pwdata[rcim_pkg::GAIN_BITS-1:0];
        rcim_pkg::REG_MOUSE_PITCH_GAIN: pitch_gain_q <= pwdata[rcim_pkg::GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rcim_pkg::REG_STICK_RANGE:      prdata = DW'(range_q);
      rcim_pkg::REG_DEADBAND:         prdata = DW'(deadband_q);
      rcim_pkg::REG_MOUSE_YAW_GAIN:   prdata = DW'(yaw_gain_q);
      rcim_pkg::REG_MOUSE_PITCH_GAIN: prdata = DW'(pitch_gain_q);
      default:                        prdata = '0;
    endcase
  end

  rcim_front #(
    .STICK_BITS(STICK_BITS)
  ) u_front (
    .start_i         (start),
    .full_i          (q_full),
    .link_live_i     (link_live_i),
    .left_switch_i   (left_switch_i),
    .right_switch_i  (right_switch_i),
    .left_stick_x_i  (left_stick_x_i),
    .left_stick_y_i  (left_stick_y_i),
    .right_stick_x_i (right_stick_x_i),
    .right_stick_y_i (right_stick_y_i),
    .wheel_value_i   (wheel_value_i),
    .key_bits_i      (key_bits_i),
    .mouse_dx_i      (mouse_dx_i),
    .mouse_dy_i      (mouse_dy_i),
    .mouse_buttons_i (mouse_buttons_i),
    .busy_o          (busy),
    .push_o          (push),
    .cmd_o           (front_cmd),
    .sticks_o        (front_sticks)
  );

  rcim_queue #(
    .WIDTH(ENTRY_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({front_cmd, front_sticks}),
    .pop_i   (pop),
    .data_o  (head_entry),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  assign head_cmd    = head_entry[ENTRY_W-1:STK_W];
  assign head_sticks = head_entry[STK_W-1:0];

  rcim_back #(
    .STICK_BITS(STICK_BITS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .empty_i            (q_empty),
    .cmd_i              (head_cmd),
    .sticks_i           (head_sticks),
    .pop_o              (pop),
    .range_i            (range_eff),
    .deadband_i         (deadband_q),
    .yaw_gain_i         (yaw_gain_q),
    .pitch_gain_i       (pitch_gain_q),
    .result_valid_o     (result_valid_o),
    .status_o           (status_o),
    .mode_o             (mode_o),
    .source_o           (source_o),
    .chassis_forward_o  (chassis_forward_o),
    .chassis_lateral_o  (chassis_lateral_o),
    .chassis_turn_o     (chassis_turn_o),
    .gimbal_yaw_o       (gimbal_yaw_o),
    .gimbal_pitch_o     (gimbal_pitch_o),
    .friction_request_o (friction_request_o),
    .fire_request_o     (fire_request_o)
  );

endmodule

// ----- hdl/rcim_checker.sv -----
module rcim_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   result_valid_o,
  input logic                                   status_o,
  input logic [1:0]                             mode_o,
  input logic                                   source_o,
  input logic signed [rcim_pkg::AXIS_BITS-1:0]  chassis_forward_o,
  input logic signed [rcim_pkg::AXIS_BITS-1:0]  chassis_turn_o,
  input logic                                   friction_request_o,
  input logic                                   fire_request_o
);

  localparam logic [rcim_pkg::AXIS_BITS-1:0] MOST_NEG = {1'b1, {rcim_pkg::Q_BITS{1'b0}}};

  a_invalid_beat_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o |-> mode_o == rcim_pkg::MODE_NONE && !source_o)
    else $error("invalid beat carries mode or source");

  a_remote_no_shooter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !source_o |-> !friction_request_o && !fire_request_o)
    else $error("shooter request on stick beat");

  a_keyboard_no_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && source_o |-> chassis_turn_o == '0)
    else $error("turn request on keyboard beat");

  a_forward_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> chassis_forward_o != MOST_NEG)
    else $error("forward request out of Q1.15 range");

endmodule

bind remote_control_intent_mapper rcim_checker u_rcim_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .result_valid_o     (result_valid_o),
  .status_o           (status_o),
  .mode_o             (mode_o),
  .source_o           (source_o),
  .chassis_forward_o  (chassis_forward_o),
  .chassis_turn_o     (chassis_turn_o),
  .friction_request_o (friction_request_o),
  .fire_request_o     (fire_request_o)
);
